// ----- rtl/rc_pulse_servo_position_comparator_defines.svh -----
// assertion macros shared by the servo comparator modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef RC_PULSE_SERVO_POSITION_COMPARATOR_DEFINES_SVH
`define RC_PULSE_SERVO_POSITION_COMPARATOR_DEFINES_SVH

// same-cycle implication
`define RCPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rcpc_pkg.sv -----
// shared constants and types of the rc servo position comparator
// no dependencies
package rcpc_pkg;

    localparam int unsigned WIDTH_BITS_DEFAULT = 16;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned POT_W       = 10;
    localparam int unsigned DZ_W        = 10;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH = 2'd2;

    localparam logic [DZ_W-1:0]  DEADZONE_RESET  = 10'd50;
    localparam logic [CFG_W-1:0] MIN_WIDTH_RESET = 16'd1400;
    localparam logic [CFG_W-1:0] MAX_WIDTH_RESET = 16'd1800;

    localparam logic [POS_W-1:0] SCALE_TOP = 10'd1000;

    // pot scaling: pot * 1000 / full scale
    localparam int unsigned      POT_DEN_W      = 16;
    localparam logic [POT_DEN_W-1:0] POT_FULL_SCALE = 16'd1023;
    localparam int unsigned      FB_NUM_W       = POT_W + POS_W;

    // quotient bits produced by the serial dividers, one per cycle
    localparam int unsigned QUOT_W = 12;

    typedef struct packed {
        logic zero_span;
        logic at_low;
        logic at_high;
    } cmd_flags_t;

endpackage

// ----- rtl/rcpc_if.sv -----
// handshake channel interfaces of the rc servo position comparator
// depends on rcpc_pkg
interface rcpc_tick_if;
    logic                       valid;
    logic                       ready;
    logic                       ppm_level;
    logic [rcpc_pkg::POT_W-1:0] pot_sample;

    modport source (output valid, output ppm_level, output pot_sample, input ready);
    modport sink   (input valid, input ppm_level, input pot_sample, output ready);
endinterface

interface rcpc_result_if;
    logic                       valid;
    logic                       ready;
    logic                       motor_a;
    logic                       motor_b;
    logic [rcpc_pkg::POS_W-1:0] command_position;
    logic [rcpc_pkg::POS_W-1:0] feedback_position;

    modport source (output valid, output motor_a, output motor_b,
                    output command_position, output feedback_position, input ready);
    modport sink   (input valid, input motor_a, input motor_b,
                    input command_position, input feedback_position, output ready);
endinterface

// ----- rtl/rcpc_width_tracker.sv -----
// pulse width counter, edge detection, self-calibrating bounds and config registers
// depends on rcpc_pkg
module rcpc_width_tracker #(
    parameter int unsigned WIDTH_BITS = rcpc_pkg::WIDTH_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rcpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcpc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             tick_en,
    input  logic                             ppm_level,
    output logic [WIDTH_BITS-1:0]            span,
    output logic [WIDTH_BITS-1:0]            range,
    output rcpc_pkg::cmd_flags_t             flags,
    output logic [rcpc_pkg::DZ_W-1:0]        deadzone
);
    import rcpc_pkg::*;

    typedef logic [WIDTH_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    count_t          counter_reg;
    logic            prev_level_reg;
    count_t          last_width_reg;
    count_t          low_bound_reg;
    count_t          high_bound_reg;
    logic [DZ_W-1:0] deadzone_reg;

    count_t counter_next;
    logic   rise;
    logic   fall;

    assign rise = ppm_level && !prev_level_reg;
    assign fall = !ppm_level && prev_level_reg;

    always_comb
    begin
        if (rise)
        begin
            counter_next = '0;
        end
        else if (counter_reg == COUNT_MAX)
        begin
            counter_next = counter_reg;
        end
        else
        begin
            counter_next = counter_reg + count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            prev_level_reg <= 1'b0;
            last_width_reg <= count_t'(MIN_WIDTH_RESET);
            low_bound_reg  <= count_t'(MIN_WIDTH_RESET);
            high_bound_reg <= count_t'(MAX_WIDTH_RESET);
            deadzone_reg   <= DEADZONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEADZONE:
                begin
                    deadzone_reg <= cfg_wdata[DZ_W-1:0];
                end
                CFG_MIN_WIDTH:
                begin
                    low_bound_reg  <= count_t'(cfg_wdata);
                    last_width_reg <= count_t'(cfg_wdata);
                end
                CFG_MAX_WIDTH:
                begin
                    high_bound_reg <= count_t'(cfg_wdata);
                end
                default:
                begin
                end
            endcase
        end
        else if (tick_en)
        begin
            counter_reg    <= counter_next;
            prev_level_reg <= ppm_level;
            if (fall)
            begin
                last_width_reg <= counter_next;
                if (counter_next < low_bound_reg)
                begin
                    low_bound_reg <= counter_next;
                end
                if (counter_next > high_bound_reg)
                begin
                    high_bound_reg <= counter_next;
                end
            end
        end
    end

    assign span            = last_width_reg - low_bound_reg;
    assign range           = high_bound_reg - low_bound_reg;
    assign flags.zero_span = high_bound_reg <= low_bound_reg;
    assign flags.at_low    = last_width_reg <= low_bound_reg;
    assign flags.at_high   = last_width_reg >= high_bound_reg;
    assign deadzone        = deadzone_reg;

endmodule

// ----- rtl/rcpc_serial_div.sv -----
// restoring divider, one quotient bit per cycle, divisor shifted right each step
// depends on rcpc_pkg and the assertion macro header
`include "rc_pulse_servo_position_comparator_defines.svh"

module rcpc_serial_div #(
    parameter int unsigned NUM_W  = 26,
    parameter int unsigned DEN_W  = 16,
    parameter int unsigned QUOT_W = rcpc_pkg::QUOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);
    import rcpc_pkg::*;

    localparam int unsigned SHIFT_W = DEN_W + QUOT_W - 1;
    localparam int unsigned CMP_W   = (NUM_W > SHIFT_W) ? NUM_W : SHIFT_W;
    localparam int unsigned CNT_W   = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

    logic [CMP_W-1:0]  rem_reg;
    logic [CMP_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // datapath: rem, shifted divisor and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= CMP_W'(num);
            dsh_reg  <= CMP_W'(den) << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    `RCPC_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `RCPC_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider did not go busy after start")
    `RCPC_ASSERT_NOW(a_done_after_busy, done_reg, !busy_reg && $past(busy_reg),
        "divider done without a finished run")

endmodule

// ----- rtl/rc_pulse_servo_position_comparator.sv -----
// rc servo position comparator: pulse width tracking, serial scaling, bang-bang drive
// an input goes through the idle, start, wait and done states; a new one is taken
// only in idle; the 12-step bit-serial dividers scale command and feedback in parallel;
// the result register frees the input side while a result waits to be taken
// reset: asynchronous active-low; bounds reload their seeds, counter and level clear
// depends on rcpc_pkg, rcpc_if, rcpc_width_tracker, rcpc_serial_div and the macro header
`include "rc_pulse_servo_position_comparator_defines.svh"

module rc_pulse_servo_position_comparator #(
    parameter int unsigned WIDTH_BITS = rcpc_pkg::WIDTH_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rcpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcpc_pkg::CFG_W-1:0]       cfg_wdata,
    rcpc_tick_if.sink                        tick,
    rcpc_result_if.source                    result
);
    import rcpc_pkg::*;

    localparam int unsigned CMD_NUM_W = WIDTH_BITS + POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [POT_W-1:0] pot_reg;
    logic             out_valid_reg;
    logic             motor_a_reg;
    logic             motor_b_reg;
    logic [POS_W-1:0] cmd_pos_reg;
    logic [POS_W-1:0] fb_pos_reg;

    logic                  tick_xfer;
    logic                  div_start;
    logic                  out_load;
    logic [WIDTH_BITS-1:0] span;
    logic [WIDTH_BITS-1:0] range;
    cmd_flags_t            flags;
    logic [DZ_W-1:0]       deadzone;
    logic [CMD_NUM_W-1:0]  cmd_num;
    logic [FB_NUM_W-1:0]   fb_num;
    logic                  cmd_done;
    logic                  fb_done;
    logic [QUOT_W-1:0]     cmd_quot;
    logic [QUOT_W-1:0]     fb_quot;
    logic [POS_W-1:0]      cmd_pos;
    logic [POS_W-1:0]      fb_pos;
    logic                  cmd_ahead;
    logic [POS_W-1:0]      pos_diff;
    logic                  brake;

    assign tick.ready = state_reg == S_IDLE;
    assign tick_xfer  = tick.valid && tick.ready;
    assign div_start  = state_reg == S_START;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    rcpc_width_tracker #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick_en   (tick_xfer),
        .ppm_level (tick.ppm_level),
        .span      (span),
        .range     (range),
        .flags     (flags),
        .deadzone  (deadzone)
    );

    // numerators scaled by 1000 before the serial division
    assign cmd_num = CMD_NUM_W'(span) * CMD_NUM_W'(SCALE_TOP);
    assign fb_num  = FB_NUM_W'(pot_reg) * FB_NUM_W'(SCALE_TOP);

    rcpc_serial_div #(
        .NUM_W  (CMD_NUM_W),
        .DEN_W  (WIDTH_BITS),
        .QUOT_W (QUOT_W)
    ) u_cmd_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (cmd_num),
        .den   (range),
        .done  (cmd_done),
        .quot  (cmd_quot)
    );

    rcpc_serial_div #(
        .NUM_W  (FB_NUM_W),
        .DEN_W  (POT_DEN_W),
        .QUOT_W (QUOT_W)
    ) u_fb_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (fb_num),
        .den   (POT_FULL_SCALE),
        .done  (fb_done),
        .quot  (fb_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_xfer)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (cmd_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command: 0 on zero or inverted range or width <= low bound, 1000 if >= high bound
    always_comb
    begin
        if (flags.zero_span || flags.at_low)
        begin
            cmd_pos = '0;
        end
        else if (flags.at_high)
        begin
            cmd_pos = SCALE_TOP;
        end
        else
        begin
            cmd_pos = cmd_quot[POS_W-1:0];
        end
    end

    assign fb_pos    = (fb_quot > QUOT_W'(SCALE_TOP)) ? SCALE_TOP : fb_quot[POS_W-1:0];
    assign cmd_ahead = cmd_pos > fb_pos;
    assign pos_diff  = cmd_ahead ? (cmd_pos - fb_pos) : (fb_pos - cmd_pos);
    assign brake     = pos_diff < deadzone;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            pot_reg <= tick.pot_sample;
        end
        if (out_load)
        begin
            motor_a_reg <= brake || cmd_ahead;
            motor_b_reg <= brake || !cmd_ahead;
            cmd_pos_reg <= cmd_pos;
            fb_pos_reg  <= fb_pos;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.motor_a           = motor_a_reg;
    assign result.motor_b           = motor_b_reg;
    assign result.command_position  = cmd_pos_reg;
    assign result.feedback_position = fb_pos_reg;

    `RCPC_ASSERT_NOW(a_div_lockstep, cmd_done || fb_done, cmd_done && fb_done,
        "command and feedback dividers out of step")
    `RCPC_ASSERT_NEXT(a_xfer_starts, tick_xfer, state_reg == S_START,
        "input transfer did not start the dividers")
    `RCPC_ASSERT_NOW(a_done_in_wait, cmd_done, state_reg == S_WAIT,
        "divider finished outside the wait state")
    `RCPC_ASSERT_NOW(a_pos_range, out_valid_reg,
        cmd_pos_reg <= SCALE_TOP && fb_pos_reg <= SCALE_TOP,
        "reported position above full scale")

endmodule
